// ===== src/ffpa_pkg.sv =====
// Package: constants, request/result types and opcode/status codes for the pool allocator.
package ffpa_pkg;

    localparam int unsigned PoolBytesDefault = 4096;
    localparam logic [15:0] PoolHdrBytes    = 16'd8;
    localparam logic [15:0] BlkHdrBytes     = 16'd4;
    localparam logic [15:0] OffsetMask      = 16'hfffc;

    localparam logic [1:0] OP_FORMAT = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NOTALLOC = 2'd2;
    localparam logic [1:0] ST_CORRUPT = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] size_bytes;
        logic [15:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data_offset;
        logic        pool_empty;
        logic [15:0] largest_free_hint;
    } t_rsp;

endpackage

// ===== src/ffpa_ram.sv =====
// Generic single-port RAM with registered read data.
module ffpa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write or read one word per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/first_fit_pool_allocator_core.sv =====
// Top level: first-fit boundary-tag pool allocator sequencer around one header RAM.
// Each request steps through its own sequence of states. The header RAM has one port and
// registered read data, so a header read passes through an address state, a data state and
// the state that uses it, and a write rides along with a state. An allocate does the size
// check, walks the block chain, then splits, flags and does the final read. The walk length
// sets how long an allocate takes: it is the number of blocks in the pool, over two passes
// at most. Requests are taken one at a time. A finished result sits in an output register
// while the next request enters; a request that finishes while that result is still
// waiting holds in its last state until the result is taken.
module first_fit_pool_allocator_core
#(
    parameter int unsigned POOL_BYTES = ffpa_pkg::PoolBytesDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ffpa_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output ffpa_pkg::t_rsp  o_rsp,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [16:0]     i_cfg_data
);
    import ffpa_pkg::*;

    localparam int unsigned Depth = POOL_BYTES / 4;
    localparam int unsigned Aw    = $clog2(Depth);
    localparam logic [16:0] Cap   = 17'(POOL_BYTES) & 17'h1fffc;

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RD      = 5'd1;   // issue read of r_addr
    localparam logic [4:0] S_RW      = 5'd2;   // read data arrives, dispatch on r_ret
    localparam logic [4:0] S_EMPTY   = 5'd3;
    localparam logic [4:0] S_DONE    = 5'd4;
    localparam logic [4:0] S_FMT     = 5'd5;
    localparam logic [4:0] S_ALCHK   = 5'd6;
    localparam logic [4:0] S_SCHK    = 5'd7;
    localparam logic [4:0] S_SNXT    = 5'd8;
    localparam logic [4:0] S_SEND    = 5'd9;
    localparam logic [4:0] S_AFOUND  = 5'd10;
    localparam logic [4:0] S_ASPL1   = 5'd11;
    localparam logic [4:0] S_ASPL2   = 5'd12;
    localparam logic [4:0] S_ASPL3   = 5'd13;
    localparam logic [4:0] S_AFLAG   = 5'd14;
    localparam logic [4:0] S_FHDR    = 5'd15;
    localparam logic [4:0] S_FN      = 5'd16;
    localparam logic [4:0] S_FNN     = 5'd17;
    localparam logic [4:0] S_FNNW    = 5'd18;
    localparam logic [4:0] S_FRH     = 5'd19;
    localparam logic [4:0] S_FPV     = 5'd20;
    localparam logic [4:0] S_FPN     = 5'd21;
    localparam logic [4:0] S_FPNW    = 5'd22;
    localparam logic [4:0] S_FPW     = 5'd23;

    logic [4:0]  r_state, n_state;
    logic [4:0]  r_ret, n_ret;
    t_req        r_req, n_req;
    logic [16:0] r_pool, n_pool;
    logic [15:0] r_total, n_total, r_lf, n_lf, r_ff, n_ff;
    logic [15:0] r_addr, n_addr;
    logic [15:0] r_h, n_h, r_n, n_n, r_pv, n_pv;
    logic [31:0] r_hw, n_hw, r_nw, n_nw;
    logic [15:0] r_need, n_need, r_best, n_best;
    logic [Aw:0] r_vis, n_vis;
    logic        r_entire, n_entire, r_pass2, n_pass2;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_data, n_data;
    logic        r_ovalid, n_ovalid;
    t_rsp        r_rsp, n_rsp;

    logic        ram_we;
    logic [Aw-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata, rd;
    logic [15:0] wr_addr;
    logic        wr_en;
    logic        rd_ok;

    ffpa_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // out-of-store accesses read zero and drop writes
    function automatic logic in_store(input logic [15:0] a);
        in_store = (32'(a) >> 2) < Depth;
    endfunction

    function automatic logic beyond(input logic [15:0] h, input logic [15:0] tot);
        beyond = (h < PoolHdrBytes) || (16'(h - PoolHdrBytes) >= tot);
    endfunction

    assign rd        = rd_ok ? ram_rdata : 32'd0;
    assign ram_we    = wr_en && in_store(wr_addr);
    assign ram_addr  = Aw'(wr_en ? (wr_addr >> 2) : (r_addr >> 2));
    assign o_ready   = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_rsp     = r_rsp;

    logic r_rd_ok;
    always_ff @(posedge i_clk) begin
        r_rd_ok <= in_store(r_addr);
    end
    assign rd_ok = r_rd_ok;

    // main sequencer
    always_comb begin
        logic [16:0] pb;
        logic [16:0] need32;
        logic [15:0] nx, usable, nn, np, nnx, hdr, a;
        n_state = r_state; n_ret = r_ret; n_req = r_req; n_pool = r_pool;
        n_total = r_total; n_lf = r_lf; n_ff = r_ff; n_addr = r_addr;
        n_h = r_h; n_n = r_n; n_pv = r_pv; n_hw = r_hw; n_nw = r_nw;
        n_need = r_need; n_best = r_best; n_vis = r_vis;
        n_entire = r_entire; n_pass2 = r_pass2; n_status = r_status; n_data = r_data;
        n_ovalid = r_ovalid; n_rsp = r_rsp;
        wr_en = 1'b0; wr_addr = r_addr; ram_wdata = 32'd0;
        pb = 17'd0; need32 = 17'd0; nx = 16'd0; usable = 16'd0; nn = 16'd0;
        np = 16'd0; nnx = 16'd0; hdr = 16'd0; a = 16'd0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_pool = i_cfg_data;
                end
                if (i_valid) begin
                    n_req = i_req; n_status = ST_OK; n_data = 16'd0;
                    case (i_req.opcode)
                        OP_FORMAT: n_state = S_FMT;
                        OP_ALLOC:  n_state = S_ALCHK;
                        OP_FREE:   n_state = S_FHDR;
                        default:   n_state = S_EMPTY;
                    endcase
                end
            end
            S_RD: begin
                n_state = S_RW;
            end
            S_RW: begin
                n_state = r_ret;
            end
            S_FMT: begin
                pb = r_pool & 17'h1fffc;
                if (pb > Cap) pb = Cap;
                if (pb < 17'd12) begin
                    n_status = ST_NOSPACE;
                end else begin
                    n_total = 16'(pb - 17'd8);
                    n_lf = 16'(pb - 17'd12);
                    n_ff = PoolHdrBytes;
                    wr_en = 1'b1; wr_addr = PoolHdrBytes;
                    ram_wdata = {16'(pb - 17'd8), 16'd0};
                end
                n_state = S_EMPTY;
            end
            S_EMPTY: begin
                n_addr = PoolHdrBytes; n_ret = S_DONE; n_state = S_RD;
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_rsp.status = r_status;
                    n_rsp.data_offset = r_data;
                    n_rsp.pool_empty = !rd[0] &&
                        beyond(16'(PoolHdrBytes + (rd[31:16] & OffsetMask)), r_total);
                    n_rsp.largest_free_hint = r_lf;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            // ---------------- allocate ----------------
            S_ALCHK: begin
                need32 = (17'(r_req.size_bytes) + 17'd3) & 17'h1fffc;
                n_need = need32[15:0];
                n_best = 16'd0; n_vis = '0; n_pass2 = 1'b0;
                if (r_req.size_bytes > r_lf || need32[16]) begin
                    n_status = ST_NOSPACE; n_state = S_EMPTY;
                end else if (r_ff > PoolHdrBytes) begin
                    n_entire = 1'b0; n_h = r_ff; n_addr = r_ff;
                    n_ret = S_SCHK; n_state = S_RD;
                end else begin
                    n_entire = 1'b1; n_pass2 = 1'b1; n_h = PoolHdrBytes;
                    n_addr = PoolHdrBytes; n_ret = S_SCHK; n_state = S_RD;
                end
            end
            S_SCHK: begin
                // header word of r_h available
                n_hw = rd; nx = rd[31:16];
                usable = 16'(nx - BlkHdrBytes);
                n_state = S_SNXT;
                if (32'(r_vis) > Depth) begin
                    n_status = ST_CORRUPT; n_state = S_SEND;
                end else begin
                    if (!rd[0]) begin
                        if (r_h < r_ff) n_ff = r_h;
                        if (usable > r_best) n_best = usable;
                        if (usable >= r_need) n_state = S_AFOUND;
                    end
                    if (n_state == S_SNXT) begin
                        nn = 16'(r_h + (nx & OffsetMask));
                        n_n = nn;
                        if (beyond(nn, r_total)) begin
                            n_status = ST_NOSPACE; n_state = S_SEND;
                        end else if (nn == r_h) begin
                            n_status = ST_CORRUPT; n_state = S_SEND;
                        end else begin
                            n_addr = nn; n_ret = S_SNXT; n_state = S_RD;
                        end
                    end
                end
            end
            S_SNXT: begin
                // prev field of next block available
                if ((r_hw[31:16] & OffsetMask) != (rd[15:0] & OffsetMask)) begin
                    n_status = ST_CORRUPT; n_state = S_SEND;
                end else begin
                    n_h = r_n; n_addr = r_n; n_vis = r_vis + (Aw+1)'(1);
                    n_ret = S_SCHK; n_state = S_RD;
                end
            end
            S_SEND: begin
                // walk ended without a fit
                if (r_entire) n_lf = r_best;
                if (r_status == ST_NOSPACE && !r_pass2) begin
                    n_status = ST_OK; n_pass2 = 1'b1; n_entire = 1'b1;
                    n_best = 16'd0; n_vis = '0; n_h = PoolHdrBytes;
                    n_addr = PoolHdrBytes; n_ret = S_SCHK; n_state = S_RD;
                end else begin
                    n_state = S_EMPTY;
                end
            end
            S_AFOUND: begin
                nx = r_hw[31:16];
                usable = 16'(nx - BlkHdrBytes);
                np = 16'(r_need + BlkHdrBytes);
                n_data = 16'(r_h + BlkHdrBytes);
                if (17'(usable) > 17'(r_need) + 17'd4) begin
                    nn = 16'(r_h + np); nnx = 16'(nx - np);
                    n_n = nn; n_pv = nnx;
                    wr_en = 1'b1; wr_addr = nn; ram_wdata = {nnx, np};
                    if (r_ff == r_h) n_ff = nn;
                    n_hw = {np, r_hw[15:0]};
                    n_state = S_ASPL1;
                end else begin
                    n_state = S_AFLAG;
                end
            end
            S_ASPL1: begin
                nn = 16'(r_n + (r_pv & OffsetMask));
                if (!beyond(nn, r_total)) begin
                    n_addr = nn; n_ret = S_ASPL2; n_state = S_RD;
                end else begin
                    n_state = S_AFLAG;
                end
            end
            S_ASPL2: begin
                wr_en = 1'b1; wr_addr = r_addr; ram_wdata = {rd[31:16], r_pv};
                n_state = S_AFLAG;
            end
            S_AFLAG: begin
                wr_en = 1'b1; wr_addr = r_h; ram_wdata = {r_hw[31:16], r_hw[15:1], 1'b1};
                n_state = S_EMPTY;
            end
            S_ASPL3: begin
                n_state = S_EMPTY;
            end
            // ---------------- free ----------------
            S_FHDR: begin
                hdr = 16'(r_req.free_offset - BlkHdrBytes);
                n_h = hdr;
                if (r_req.free_offset[1:0] != 2'd0 || beyond(hdr, r_total)) begin
                    n_status = ST_NOTALLOC; n_state = S_EMPTY;
                end else begin
                    n_addr = hdr; n_ret = S_FN; n_state = S_RD;
                end
            end
            S_FN: begin
                if (!rd[0]) begin
                    n_status = ST_NOTALLOC; n_state = S_EMPTY;
                end else begin
                    n_hw = {rd[31:16], rd[15:1], 1'b0};
                    if (r_h < r_ff) n_ff = r_h;
                    nn = 16'(r_h + (rd[31:16] & OffsetMask));
                    n_n = nn;
                    if (!beyond(nn, r_total)) begin
                        n_addr = nn; n_ret = S_FNN; n_state = S_RD;
                    end else begin
                        n_state = S_FRH;
                    end
                end
            end
            S_FNN: begin
                n_nw = rd;
                if (!rd[0]) begin
                    nx = 16'(r_hw[31:16] + rd[31:16]);
                    n_hw = {nx, r_hw[15:0]};
                    usable = 16'(nx - BlkHdrBytes);
                    if (usable > r_lf) n_lf = usable;
                    nn = 16'(r_n + (rd[31:16] & OffsetMask));
                    if (!beyond(nn, r_total)) begin
                        n_addr = nn; n_ret = S_FNNW; n_state = S_RD;
                    end else begin
                        n_state = S_FRH;
                    end
                end else begin
                    n_state = S_FRH;
                end
            end
            S_FNNW: begin
                wr_en = 1'b1; wr_addr = r_addr;
                ram_wdata = {rd[31:16], 16'(rd[15:0] + r_nw[15:0])};
                n_state = S_FRH;
            end
            S_FRH: begin
                // write back the cleared (and possibly grown) header
                wr_en = 1'b1; wr_addr = r_h; ram_wdata = r_hw;
                a = 16'(r_h - (r_hw[15:0] & OffsetMask));
                n_pv = a;
                if (a != r_h) begin
                    n_addr = a; n_ret = S_FPV; n_state = S_RD;
                end else begin
                    n_state = S_EMPTY;
                end
            end
            S_FPV: begin
                n_nw = rd;
                if (!rd[0]) begin
                    nn = 16'(r_h + (r_hw[31:16] & OffsetMask));
                    n_n = nn;
                    if (!beyond(nn, r_total)) begin
                        n_addr = nn; n_ret = S_FPNW; n_state = S_RD;
                    end else begin
                        n_state = S_FPW;
                    end
                end else begin
                    n_state = S_EMPTY;
                end
            end
            S_FPNW: begin
                wr_en = 1'b1; wr_addr = r_addr;
                ram_wdata = {rd[31:16], 16'(rd[15:0] + r_hw[15:0])};
                n_state = S_FPW;
            end
            S_FPW: begin
                nx = 16'(r_nw[31:16] + r_hw[31:16]);
                wr_en = 1'b1; wr_addr = r_pv; ram_wdata = {nx, r_nw[15:0]};
                // a left neighbor outside the store drops the write and still reads zero
                usable = 16'((in_store(r_pv) ? nx : 16'd0) - BlkHdrBytes);
                if (usable > r_lf) n_lf = usable;
                if (r_pv < n_ff) n_ff = r_pv;
                n_state = S_EMPTY;
            end
            S_FPN: begin
                n_state = S_EMPTY;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0; r_pool <= 17'd4096;
            r_total <= 16'd0; r_lf <= 16'd0; r_ff <= PoolHdrBytes;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid; r_pool <= n_pool;
            r_total <= n_total; r_lf <= n_lf; r_ff <= n_ff;
        end
        r_ret <= n_ret; r_req <= n_req; r_addr <= n_addr; r_h <= n_h; r_n <= n_n;
        r_pv <= n_pv; r_hw <= n_hw; r_nw <= n_nw; r_need <= n_need; r_best <= n_best;
        r_vis <= n_vis; r_entire <= n_entire; r_pass2 <= n_pass2;
        r_status <= n_status; r_data <= n_data; r_rsp <= n_rsp;
    end
endmodule
